[hw/rtl/hsv_color_threshold_assert.svh]
// assertion macros used by the hsv color threshold checker
`ifndef HSV_COLOR_THRESHOLD_ASSERT_SVH
`define HSV_COLOR_THRESHOLD_ASSERT_SVH

// same-cycle implication, off while reset is low
`define HCT_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("hsv_color_threshold: same-cycle check failed");

// next-cycle implication, off while reset is low
`define HCT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("hsv_color_threshold: next-cycle check failed");

`endif

[hw/rtl/hct_pkg.sv]
// shared widths, register codes and reset values of the hsv color threshold
`timescale 1ns / 1ps

package hct_pkg;

    localparam int CHAN_W     = 8;   // one color channel, also brightness
    localparam int HUE_W      = 9;   // whole degrees 0..359
    localparam int SAT_W      = 7;   // whole percent 0..100
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;   // widest register

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUE_LOW  = 3'd0,
        REG_HUE_HIGH = 3'd1,
        REG_SAT_LOW  = 3'd2,
        REG_SAT_HIGH = 3'd3,
        REG_VAL_LOW  = 3'd4,
        REG_VAL_HIGH = 3'd5
    } cfg_reg_t;

    localparam logic [HUE_W-1:0]  HUE_LOW_RST  = 9'd90;
    localparam logic [HUE_W-1:0]  HUE_HIGH_RST = 9'd150;
    localparam logic [SAT_W-1:0]  SAT_LOW_RST  = 7'd15;
    localparam logic [SAT_W-1:0]  SAT_HIGH_RST = 7'd100;
    localparam logic [CHAN_W-1:0] VAL_LOW_RST  = 8'd25;
    localparam logic [CHAN_W-1:0] VAL_HIGH_RST = 8'd255;

endpackage

[hw/rtl/hct_stream_if.sv]
// pixel and result stream interfaces of the hsv color threshold
`timescale 1ns / 1ps

interface hct_pix_if;
    logic                       valid;
    logic                       ready;
    logic [hct_pkg::CHAN_W-1:0] red;
    logic [hct_pkg::CHAN_W-1:0] green;
    logic [hct_pkg::CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface hct_res_if;
    logic                       valid;
    logic                       ready;
    logic                       keep;
    logic [hct_pkg::HUE_W-1:0]  hue_whole;
    logic [hct_pkg::SAT_W-1:0]  sat_whole;
    logic [hct_pkg::CHAN_W-1:0] brightness;

    modport source (output valid, output keep, output hue_whole, output sat_whole,
                    output brightness, input ready);
    modport sink (input valid, input keep, input hue_whole, input sat_whole,
                  input brightness, output ready);
endinterface

[hw/rtl/hsv_color_threshold.sv]
// top level: rgb pixel to hsv conversion with hue, saturation and value window test
`timescale 1ns / 1ps

// One pixel beat enters per clock while pix.ready is high, and one result beat leaves
// per pixel, in order. A pixel passes twelve registered stages from accept to a valid
// result: one stage finds the largest and smallest channel, one forms the exact hue
// and saturation numerators, nine stages run a restoring divider that retires one
// quotient bit per stage for hue and saturation side by side, and the last stage makes
// the window decisions into the output register. The divider depth (nine quotient bits
// for hue 0..359) sets the latency. Every stage carries its own valid bit and stalls
// only when it and all stages after it are full, so bubbles close up and pix.ready
// stays high while the output waits until all twelve stages hold a beat. All window
// tests are exact: they use the whole-unit quotient and whether the remainder is zero,
// so no rounding happens. A gray pixel reports hue 0 and saturation 0. The hue window
// wraps through 0 when hue_low is not below hue_high. Configuration is written through
// cfg_we/cfg_index/cfg_data while no pixel is in flight, a user rule the block does
// not enforce. Unknown indexes are ignored. No memory, no clearing pass after reset.

module hsv_color_threshold (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [hct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hct_pkg::CFG_DATA_W-1:0] cfg_data,
    hct_pix_if.sink                      pix,
    hct_res_if.source                    res
);
    import hct_pkg::*;

    localparam int Q_W        = 9;           // quotient bits, covers hue 0..359
    localparam int REM_W      = 17;          // 360 * 255 and 255 << 8 both fit
    localparam int DIV_STAGES = Q_W;
    localparam int NST        = DIV_STAGES + 3;   // prep, numerators, divider, output

    localparam logic [HUE_W-1:0] DEG_RED   = 9'd0;
    localparam logic [HUE_W-1:0] DEG_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] DEG_BLUE  = 9'd240;
    localparam logic [HUE_W-1:0] DEG_WRAP  = 9'd360;
    localparam logic [HUE_W-1:0] DEG_STEP  = 9'd60;
    localparam logic [SAT_W-1:0] PCT_FULL  = 7'd100;

    // which channel is the max, and the red-wrap case
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE,
        SEC_RED_WRAP
    } sector_t;

    typedef struct packed {
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] d;
        logic [CHAN_W-1:0] x;
        logic              neg;
        sector_t           sector;
    } prep_t;

    typedef struct packed {
        logic [REM_W-1:0]  hrem;
        logic [Q_W-1:0]    hq;
        logic [REM_W-1:0]  srem;
        logic [Q_W-1:0]    sq;
        logic [CHAN_W-1:0] d;
        logic [CHAN_W-1:0] mx;
        logic              gray;
    } div_t;

    // ---------------------------------------------------------------- config
    logic [HUE_W-1:0]  hue_low_reg, hue_high_reg;
    logic [SAT_W-1:0]  sat_low_reg, sat_high_reg;
    logic [CHAN_W-1:0] val_low_reg, val_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg  <= HUE_LOW_RST;
            hue_high_reg <= HUE_HIGH_RST;
            sat_low_reg  <= SAT_LOW_RST;
            sat_high_reg <= SAT_HIGH_RST;
            val_low_reg  <= VAL_LOW_RST;
            val_high_reg <= VAL_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HUE_LOW:  hue_low_reg  <= cfg_data[HUE_W-1:0];
                REG_HUE_HIGH: hue_high_reg <= cfg_data[HUE_W-1:0];
                REG_SAT_LOW:  sat_low_reg  <= cfg_data[SAT_W-1:0];
                REG_SAT_HIGH: sat_high_reg <= cfg_data[SAT_W-1:0];
                REG_VAL_LOW:  val_low_reg  <= cfg_data[CHAN_W-1:0];
                REG_VAL_HIGH: val_high_reg <= cfg_data[CHAN_W-1:0];
                default:      ;   // unknown index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------- flow control
    // stage 0: prep, 1..DIV_STAGES+1: divider chain (1 holds numerators), last: output
    logic [NST-1:0] st_valid_reg, st_valid_next;
    logic [NST-1:0] adv;

    // a stage moves when the output drains or some stage at or after it is empty
    for (genvar i = 0; i < NST; i++)
    begin : g_adv
        assign adv[i] = res.ready || !(&st_valid_reg[NST-1:i]);
    end

    assign pix.ready = adv[0];
    assign res.valid = st_valid_reg[NST-1];

    always_comb
    begin
        st_valid_next[0] = adv[0] ? pix.valid : st_valid_reg[0];
        for (int i = 1; i < NST; i++)
        begin
            st_valid_next[i] = adv[i] ? st_valid_reg[i-1] : st_valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= '0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    // ----------------------------------------------- stage 0: max, min, sector
    prep_t             prep_reg, prep_next;
    logic              r_max, g_max;
    logic [CHAN_W-1:0] mn;

    always_comb
    begin
        // ties: red over green over blue
        r_max = (pix.red >= pix.green) && (pix.red >= pix.blue);
        g_max = !r_max && (pix.green >= pix.blue);

        if ((pix.red <= pix.green) && (pix.red <= pix.blue))
        begin
            mn = pix.red;
        end
        else
        begin
            mn = (pix.green <= pix.blue) ? pix.green : pix.blue;
        end

        prep_next = '0;
        if (r_max)
        begin
            prep_next.mx = pix.red;
            if (pix.green >= pix.blue)
            begin
                prep_next.sector = SEC_RED;
                prep_next.neg    = 1'b0;
                prep_next.x      = pix.green - pix.blue;
            end
            else
            begin
                // hue lands in [300, 360)
                prep_next.sector = SEC_RED_WRAP;
                prep_next.neg    = 1'b1;
                prep_next.x      = pix.blue - pix.green;
            end
        end
        else if (g_max)
        begin
            prep_next.mx     = pix.green;
            prep_next.sector = SEC_GREEN;
            prep_next.neg    = (pix.blue < pix.red);
            prep_next.x      = (pix.blue >= pix.red) ? (pix.blue - pix.red)
                                                     : (pix.red - pix.blue);
        end
        else
        begin
            prep_next.mx     = pix.blue;
            prep_next.sector = SEC_BLUE;
            prep_next.neg    = (pix.red < pix.green);
            prep_next.x      = (pix.red >= pix.green) ? (pix.red - pix.green)
                                                      : (pix.green - pix.red);
        end
        prep_next.d = prep_next.mx - mn;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prep_reg <= prep_next;
        end
    end

    // ------------------------------------- stage 1: exact hue and sat numerators
    div_t dv_reg  [DIV_STAGES+1];
    div_t dv_next [DIV_STAGES+1];

    logic [HUE_W-1:0] base_deg;
    logic [REM_W-1:0] base_term, x_term;

    always_comb
    begin
        unique case (prep_reg.sector)
            SEC_RED:      base_deg = DEG_RED;
            SEC_GREEN:    base_deg = DEG_GREEN;
            SEC_BLUE:     base_deg = DEG_BLUE;
            SEC_RED_WRAP: base_deg = DEG_WRAP;
        endcase

        base_term = REM_W'(base_deg) * REM_W'(prep_reg.d);
        x_term    = REM_W'(prep_reg.x) * REM_W'(DEG_STEP);

        dv_next[0].hrem = prep_reg.neg ? (base_term - x_term) : (base_term + x_term);
        dv_next[0].hq   = '0;
        dv_next[0].srem = REM_W'(prep_reg.d) * REM_W'(PCT_FULL);
        dv_next[0].sq   = '0;
        dv_next[0].d    = prep_reg.d;
        dv_next[0].mx   = prep_reg.mx;
        dv_next[0].gray = (prep_reg.d == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            dv_reg[0] <= dv_next[0];
        end
    end

    // ------------------------- divider: one quotient bit per stage, msb first
    // hue = hrem / d, saturation = srem / mx
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        localparam int Shift = Q_W - 1 - k;

        logic [REM_W-1:0] h_trial, s_trial;
        logic             h_take, s_take;

        always_comb
        begin
            h_trial = REM_W'(dv_reg[k].d) << Shift;
            s_trial = REM_W'(dv_reg[k].mx) << Shift;
            h_take  = (dv_reg[k].hrem >= h_trial);
            s_take  = (dv_reg[k].srem >= s_trial);

            dv_next[k+1] = dv_reg[k];
            if (h_take)
            begin
                dv_next[k+1].hrem      = dv_reg[k].hrem - h_trial;
                dv_next[k+1].hq[Shift] = 1'b1;
            end
            if (s_take)
            begin
                dv_next[k+1].srem      = dv_reg[k].srem - s_trial;
                dv_next[k+1].sq[Shift] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k+2])
            begin
                dv_reg[k+1] <= dv_next[k+1];
            end
        end
    end

    // ------------------------------------------- last stage: window decisions
    logic [Q_W-1:0]   hq, sq;
    logic             h_exact, s_exact;
    logic             hue_ge, hue_le, hue_ok, sat_ok, val_ok;
    logic             keep_reg, keep_next;
    logic [HUE_W-1:0] hue_reg;
    logic [SAT_W-1:0] sat_reg;
    logic [CHAN_W-1:0] bright_reg;

    always_comb
    begin
        // gray pixel: the hue divisor is zero, report hue 0 and saturation 0 exactly
        hq      = dv_reg[DIV_STAGES].gray ? '0 : dv_reg[DIV_STAGES].hq;
        sq      = dv_reg[DIV_STAGES].gray ? '0 : dv_reg[DIV_STAGES].sq;
        h_exact = dv_reg[DIV_STAGES].gray || (dv_reg[DIV_STAGES].hrem == '0);
        s_exact = dv_reg[DIV_STAGES].gray || (dv_reg[DIV_STAGES].srem == '0);

        // x >= L iff floor(x) >= L; x <= H iff floor(x) < H or x == H exactly
        hue_ge = (hq >= Q_W'(hue_low_reg));
        hue_le = (hq < Q_W'(hue_high_reg)) || ((hq == Q_W'(hue_high_reg)) && h_exact);
        hue_ok = (hue_low_reg < hue_high_reg) ? (hue_ge && hue_le) : (hue_ge || hue_le);

        sat_ok = (sq >= Q_W'(sat_low_reg))
              && ((sq < Q_W'(sat_high_reg)) || ((sq == Q_W'(sat_high_reg)) && s_exact));

        val_ok = (dv_reg[DIV_STAGES].mx >= val_low_reg)
              && (dv_reg[DIV_STAGES].mx <= val_high_reg);

        keep_next = hue_ok && sat_ok && val_ok;
    end

    always_ff @(posedge clk)
    begin
        if (adv[NST-1])
        begin
            keep_reg   <= keep_next;
            hue_reg    <= hq[HUE_W-1:0];
            sat_reg    <= sq[SAT_W-1:0];
            bright_reg <= dv_reg[DIV_STAGES].mx;
        end
    end

    assign res.keep       = keep_reg;
    assign res.hue_whole  = hue_reg;
    assign res.sat_whole  = sat_reg;
    assign res.brightness = bright_reg;

endmodule

[hw/rtl/hct_checker.sv]
// port-level checks of the hsv color threshold, bound to the top level
`timescale 1ns / 1ps
`include "hsv_color_threshold_assert.svh"

module hct_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       pix_ready,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic                       keep,
    input logic [hct_pkg::HUE_W-1:0]  hue_whole,
    input logic [hct_pkg::SAT_W-1:0]  sat_whole,
    input logic [hct_pkg::CHAN_W-1:0] brightness
);

    // a stalled result beat holds still
    `HCT_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(keep) && $stable(hue_whole) && $stable(sat_whole) && $stable(brightness))

    // an empty output means the whole pipe can move, so input is open
    `HCT_ASSERT_NOW(a_ready_when_drained, clk, rst_n, !res_valid, pix_ready)

    // hue and saturation stay in their ranges
    `HCT_ASSERT_NOW(a_range, clk, rst_n, res_valid, (hue_whole <= 9'd359) && (sat_whole <= 7'd100))

    // black is gray: hue and saturation read zero
    `HCT_ASSERT_NOW(a_black_gray, clk, rst_n, res_valid && (brightness == 8'd0), (hue_whole == 9'd0) && (sat_whole == 7'd0))

endmodule

bind hsv_color_threshold hct_checker u_hct_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_ready  (pix.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .keep       (res.keep),
    .hue_whole  (res.hue_whole),
    .sat_whole  (res.sat_whole),
    .brightness (res.brightness)
);

[verif/tb_hsv_color_threshold.sv]
// self-checking testbench of the hsv color threshold: directed and random pixels
`timescale 1ns / 1ps

module tb_hsv_color_threshold;

    import hct_pkg::*;

    // nominal pipeline depth from accept to result, used for drain tails
    localparam int PIPE_LAT     = 12;
    localparam int RST_CYCLES   = 12;
    // long receiver hold-off that fills the pipeline and blocks the input
    localparam int PARK_CYCLES  = 300;
    // cycles with no beat on either side before the run is declared hung
    localparam int HANG_LIMIT   = 4000;
    localparam int RAND_PHASES  = 4;
    localparam int RAND_WINDOWS = 5;
    localparam int RAND_PIXELS  = 50;

    // indexes outside the register map, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic              keep;
        logic [HUE_W-1:0]  hue_whole;
        logic [SAT_W-1:0]  sat_whole;
        logic [CHAN_W-1:0] brightness;
    } hsv_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hct_pix_if pix_bus ();
    hct_res_if res_bus ();

    hsv_color_threshold dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix_bus),
        .res       (res_bus)
    );

    // shadow copy of the window registers, kept by the beat monitor only
    int unsigned win_hue_lo, win_hue_hi;
    int unsigned win_sat_lo, win_sat_hi;
    int unsigned win_val_lo, win_val_hi;

    hsv_result_t pending_results[$];
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    logic        sink_parked  = 1'b0;
    event        park_sink;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // --------------------------------------------------------------------
    // predictor: exact hsv conversion and window test of one pixel
    // --------------------------------------------------------------------
    function automatic hsv_result_t classify_pixel(input logic [CHAN_W-1:0] r,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] b);
        int unsigned ri, gi, bi, mx, mn, d, hn, hw, sw;
        bit          hue_ok, sat_ok, val_ok, wraps;
        hsv_result_t o;
        ri = 32'(r);
        gi = 32'(g);
        bi = 32'(b);
        mx = (ri > gi) ? ((ri > bi) ? ri : bi) : ((gi > bi) ? gi : bi);
        mn = (ri < gi) ? ((ri < bi) ? ri : bi) : ((gi < bi) ? gi : bi);
        d  = mx - mn;
        // window wraps through 0 when low is not below high
        wraps = !(win_hue_lo < win_hue_hi);
        if (d == 0)
        begin
            // gray pixel: hue and saturation are exactly 0
            hw     = 0;
            sw     = 0;
            hue_ok = wraps || (win_hue_lo == 0);
            sat_ok = (win_sat_lo == 0);
        end
        else
        begin
            // hue held as hn/d in degrees; ties go red, then green
            if (mx == ri)
                hn = (gi >= bi) ? 60 * (gi - bi) : 360 * d - 60 * (bi - gi);
            else if (mx == gi)
                hn = (bi >= ri) ? 120 * d + 60 * (bi - ri) : 120 * d - 60 * (ri - bi);
            else
                hn = (ri >= gi) ? 240 * d + 60 * (ri - gi) : 240 * d - 60 * (gi - ri);
            hw = hn / d;
            sw = (100 * d) / mx;
            if (wraps)
                hue_ok = (win_hue_lo * d <= hn) || (hn <= win_hue_hi * d);
            else
                hue_ok = (win_hue_lo * d <= hn) && (hn <= win_hue_hi * d);
            sat_ok = (win_sat_lo * mx <= 100 * d) && (100 * d <= win_sat_hi * mx);
        end
        val_ok = (win_val_lo <= mx) && (mx <= win_val_hi);
        o.keep       = hue_ok && sat_ok && val_ok;
        o.hue_whole  = hw[HUE_W-1:0];
        o.sat_whole  = sw[SAT_W-1:0];
        o.brightness = mx[CHAN_W-1:0];
        return o;
    endfunction

    function automatic void check_field(input string field, input logic [HUE_W-1:0] want,
                                        input logic [HUE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // --------------------------------------------------------------------
    // beat monitor: register shadow, expected results, checks, hang watchdog
    // --------------------------------------------------------------------
    always @(posedge clk)
    begin : beat_monitor
        hsv_result_t want;
        hsv_result_t got;
        if (!rst_n)
        begin
            win_hue_lo   = 32'(HUE_LOW_RST);
            win_hue_hi   = 32'(HUE_HIGH_RST);
            win_sat_lo   = 32'(SAT_LOW_RST);
            win_sat_hi   = 32'(SAT_HIGH_RST);
            win_val_lo   = 32'(VAL_LOW_RST);
            win_val_hi   = 32'(VAL_HIGH_RST);
            quiet_cycles = 0;
        end
        else
        begin
            // register writes land at this edge, the block is idle meanwhile
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HUE_LOW:  win_hue_lo = 32'(cfg_data[HUE_W-1:0]);
                    REG_HUE_HIGH: win_hue_hi = 32'(cfg_data[HUE_W-1:0]);
                    REG_SAT_LOW:  win_sat_lo = 32'(cfg_data[SAT_W-1:0]);
                    REG_SAT_HIGH: win_sat_hi = 32'(cfg_data[SAT_W-1:0]);
                    REG_VAL_LOW:  win_val_lo = 32'(cfg_data[CHAN_W-1:0]);
                    REG_VAL_HIGH: win_val_hi = 32'(cfg_data[CHAN_W-1:0]);
                    default: ;
                endcase
            end
            // pixel beat: one result is owed for every accepted pixel
            if (pix_bus.valid && pix_bus.ready)
                pending_results.push_back(classify_pixel(pix_bus.red, pix_bus.green,
                                                         pix_bus.blue));
            // result beat: compare against the oldest owed result
            if (res_bus.valid && res_bus.ready)
            begin
                got.keep       = res_bus.keep;
                got.hue_whole  = res_bus.hue_whole;
                got.sat_whole  = res_bus.sat_whole;
                got.brightness = res_bus.brightness;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with none expected, actual %h", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("keep", HUE_W'(want.keep), HUE_W'(got.keep));
                    check_field("hue_whole", want.hue_whole, got.hue_whole);
                    check_field("sat_whole", HUE_W'(want.sat_whole), HUE_W'(got.sat_whole));
                    check_field("brightness", HUE_W'(want.brightness),
                                HUE_W'(got.brightness));
                end
            end
            // watchdog: any beat on either side counts as progress
            if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, HANG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // --------------------------------------------------------------------
    // result receiver: random stalls, or parked for a long stretch
    // --------------------------------------------------------------------
    initial
    begin
        res_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_parked)
                res_bus.ready <= 1'b0;
            else
                res_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // hold-off counter lives in its own process so the sender keeps offering
    always
    begin
        @(park_sink);
        sink_parked <= 1'b1;
        repeat (PARK_CYCLES) @(posedge clk);
        sink_parked <= 1'b0;
    end

    // --------------------------------------------------------------------
    // shared driving tasks
    // --------------------------------------------------------------------

    // offer one pixel beat and return once it is accepted; valid stays high
    task automatic offer_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                               input logic [CHAN_W-1:0] b);
        if ($urandom_range(99) < src_idle_pct)
        begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.red   <= r;
        pix_bus.green <= g;
        pix_bus.blue  <= b;
        do
            @(posedge clk);
        while (!pix_bus.ready);
    endtask

    // mix of uniform, gray, tied and nearly gray pixels
    task automatic offer_random_pixel();
        int                kind;
        logic [CHAN_W-1:0] r, g, b, base;
        kind = $urandom_range(99);
        r    = CHAN_W'($urandom);
        g    = CHAN_W'($urandom);
        b    = CHAN_W'($urandom);
        base = CHAN_W'($urandom);
        if (kind < 55)
            ;
        else if (kind < 65)
        begin
            g = r;
            b = r;
        end
        else if (kind < 80)
        begin
            // two channels tie, either as the maximum or the minimum
            case ($urandom_range(2))
                0: g = r;
                1: b = g;
                default: b = r;
            endcase
        end
        else
        begin
            r = (base > 250) ? CHAN_W'(base - $urandom_range(3))
                             : CHAN_W'(base + $urandom_range(3));
            g = (base > 250) ? CHAN_W'(base - $urandom_range(3))
                             : CHAN_W'(base + $urandom_range(3));
            b = base;
        end
        offer_pixel(r, g, b);
    endtask

    // stop offering and wait until every owed result has arrived
    task automatic wait_drain();
        pix_bus.valid <= 1'b0;
        // let the monitor log a beat accepted at the edge just passed
        @(negedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    // one register write; the caller lowers the enable after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic set_windows(input logic [CFG_DATA_W-1:0] hue_lo,
                               input logic [CFG_DATA_W-1:0] hue_hi,
                               input logic [CFG_DATA_W-1:0] sat_lo,
                               input logic [CFG_DATA_W-1:0] sat_hi,
                               input logic [CFG_DATA_W-1:0] val_lo,
                               input logic [CFG_DATA_W-1:0] val_hi);
        wait_drain();
        write_reg(REG_HUE_LOW, hue_lo);
        write_reg(REG_HUE_HIGH, hue_hi);
        write_reg(REG_SAT_LOW, sat_lo);
        write_reg(REG_SAT_HIGH, sat_hi);
        write_reg(REG_VAL_LOW, val_lo);
        write_reg(REG_VAL_HIGH, val_hi);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int src_pct, input int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // fixed probe pixels plus a few random ones, reused under many windows
    task automatic offer_probe_set();
        offer_pixel(8'd0, 8'd0, 8'd0);
        offer_pixel(8'd255, 8'd255, 8'd255);
        offer_pixel(8'd255, 8'd0, 8'd0);
        offer_pixel(8'd255, 8'd0, 8'd1);
        offer_pixel(8'd0, 8'd255, 8'd0);
        offer_pixel(8'd0, 8'd0, 8'd255);
        offer_pixel(8'd90, 8'd90, 8'd90);
        offer_pixel(8'd255, 8'd0, 8'd255);
        repeat (4) offer_random_pixel();
    endtask

    // --------------------------------------------------------------------
    // tests
    // --------------------------------------------------------------------

    // reset windows: colors on every hue sector, ties, wrap sector and grays
    task automatic test_reset_windows();
        set_idling(0, 0);
        offer_pixel(8'd0, 8'd0, 8'd0);
        offer_pixel(8'd255, 8'd255, 8'd255);
        offer_pixel(8'd128, 8'd128, 8'd128);
        offer_pixel(8'd255, 8'd0, 8'd0);
        offer_pixel(8'd0, 8'd255, 8'd0);
        offer_pixel(8'd0, 8'd0, 8'd255);
        offer_pixel(8'd255, 8'd255, 8'd0);     // red and green tie
        offer_pixel(8'd0, 8'd255, 8'd255);     // green and blue tie
        offer_pixel(8'd255, 8'd0, 8'd255);     // red and blue tie, wrap sector
        offer_pixel(8'd255, 8'd0, 8'd1);       // just below 360 degrees
        offer_pixel(8'd255, 8'd1, 8'd0);
        offer_pixel(8'd1, 8'd0, 8'd0);         // smallest chroma
        offer_pixel(8'd0, 8'd1, 8'd0);
        offer_pixel(8'd0, 8'd0, 8'd1);
        offer_pixel(8'd255, 8'd254, 8'd254);
        offer_pixel(8'd100, 8'd200, 8'd50);
        offer_pixel(8'd30, 8'd60, 8'd30);
        offer_pixel(8'd26, 8'd25, 8'd25);
        offer_pixel(8'd24, 8'd25, 8'd24);
        offer_pixel(8'd200, 8'd180, 8'd40);
        offer_pixel(8'd255, 8'd128, 8'd0);
        offer_pixel(8'd127, 8'd255, 8'd0);
        offer_pixel(8'd0, 8'd255, 8'd128);
        offer_pixel(8'd1, 8'd255, 8'd254);
    endtask

    // pixels sitting exactly on, just inside and just outside each bound
    task automatic test_exact_edges();
        set_windows(9'd60, 9'd180, 9'd50, 9'd100, 9'd100, 9'd200);
        offer_pixel(8'd255, 8'd255, 8'd0);     // hue exactly at the low bound
        offer_pixel(8'd255, 8'd254, 8'd0);     // hue a fraction below
        offer_pixel(8'd0, 8'd255, 8'd255);     // hue exactly at the high bound
        offer_pixel(8'd0, 8'd254, 8'd255);     // hue a fraction above
        offer_pixel(8'd100, 8'd200, 8'd100);   // saturation exactly 50
        offer_pixel(8'd101, 8'd200, 8'd101);   // saturation just under 50
        offer_pixel(8'd50, 8'd100, 8'd50);     // value exactly at the low bound
        offer_pixel(8'd50, 8'd99, 8'd50);
        offer_pixel(8'd0, 8'd200, 8'd0);       // value exactly at the high bound
        offer_pixel(8'd100, 8'd201, 8'd100);
    endtask

    // extreme, wrapping, out-of-range, masked and inverted windows
    task automatic test_register_extremes();
        set_windows(9'd0, 9'd359, 9'd0, 9'd100, 9'd0, 9'd255);
        offer_probe_set();
        set_windows(9'd359, 9'd0, 9'd0, 9'd100, 9'd0, 9'd255);
        offer_probe_set();
        // equal hue bounds wrap; saturation high written with all data bits set
        set_windows(9'd120, 9'd120, 9'd0, 9'h1FF, 9'd0, 9'd255);
        offer_probe_set();
        // hue bounds above 359, inverted saturation and value windows
        set_windows(9'd511, 9'd400, 9'd101, 9'd100, 9'd255, 9'd0);
        offer_probe_set();
        set_windows(9'd0, 9'd0, 9'd100, 9'd100, 9'd255, 9'd255);
        offer_probe_set();
        set_windows(9'd300, 9'd60, 9'd0, 9'd50, 9'd1, 9'd254);
        // writes outside the register map must leave every window alone
        write_reg(REG_SPARE_6, 9'h1FF);
        write_reg(REG_SPARE_7, 9'h000);
        cfg_we <= 1'b0;
        offer_probe_set();
    endtask

    // random windows and pixels under each idling mix
    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: set_idling(0, 0);
                1: set_idling(55, 0);
                2: set_idling(0, 55);
                default: set_idling(32, 32);
            endcase
            for (int w = 0; w < RAND_WINDOWS; w++)
            begin
                hue_lo = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(511, 360))
                                                  : CFG_DATA_W'($urandom_range(359));
                hue_hi = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(511, 360))
                                                  : CFG_DATA_W'($urandom_range(359));
                sat_lo = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom)
                                                  : CFG_DATA_W'($urandom_range(60));
                sat_hi = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom)
                                                  : CFG_DATA_W'($urandom_range(100, 40));
                val_lo = CFG_DATA_W'($urandom_range(128));
                val_hi = CFG_DATA_W'($urandom_range(255, 100));
                if ($urandom_range(9) == 0)
                begin
                    val_lo = CFG_DATA_W'($urandom_range(255, 129));
                    val_hi = CFG_DATA_W'($urandom_range(128));
                end
                set_windows(hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi);
                repeat (RAND_PIXELS) offer_random_pixel();
            end
        end
    endtask

    // receiver parked while pixels keep coming, then a full drain
    task automatic test_backpressure();
        set_windows(9'd30, 9'd270, 9'd10, 9'd100, 9'd20, 9'd255);
        set_idling(0, 0);
        -> park_sink;
        repeat (48) offer_random_pixel();
        wait_drain();
        set_idling(32, 32);
        repeat (24) offer_random_pixel();
    endtask

    // --------------------------------------------------------------------
    // sequence
    // --------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_HUE_LOW;
        cfg_data      = '0;
        pix_bus.valid = 1'b0;
        pix_bus.red   = '0;
        pix_bus.green = '0;
        pix_bus.blue  = '0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_windows();
        test_exact_edges();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();

        wait_drain();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
